FILE: src/erme_pkg.sv
package erme_pkg;

    localparam int VALUE_WIDTH  = 18;
    localparam int CORDIC_STEPS = 18;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int XY_W         = 38;
    localparam int Z_W          = 36;
    localparam int ACC_W        = 56;
    localparam int T_W          = 2 * VALUE_WIDTH;
    localparam int MAC_STEPS    = 17;
    localparam int SQ_W         = 36;

    localparam logic signed [Z_W-1:0]   PI30      = Z_W'(64'sd3373259426);
    localparam logic signed [Z_W-1:0]   TWO_PI30  = Z_W'(64'sd6746518852);
    localparam logic signed [Z_W-1:0]   HALF_PI30 = Z_W'(64'sd1686629713);
    localparam logic signed [XY_W-1:0]  GAIN30    = XY_W'(64'sd652032874);
    localparam logic signed [18:0]      PI14      = 19'sd51472;
    localparam logic signed [18:0]      TWO_PI14  = 19'sd102944;
    localparam logic signed [ACC_W-1:0] ACC_RND   = ACC_W'(64'sd2147483648);
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = 18'sd131071;
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = -18'sd131072;
    localparam logic signed [VALUE_WIDTH-1:0] UNIT16  = 18'sd65536;

    typedef enum logic [1:0] {
        KIND_BUILD  = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_DECOMP = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MISMATCH  = 2'd1,
        ST_NO_MATRIX = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        SRC_SX, SRC_CX, SRC_SY, SRC_CY, SRC_SZ, SRC_CZ, SRC_T, SRC_ONE
    } mac_src_t;

    typedef enum logic [2:0] {
        OP_T, OP_SET, OP_SETN, OP_ADD, OP_SUB
    } mac_op_t;

    typedef struct packed {
        mac_src_t    src_a;
        mac_src_t    src_b;
        mac_op_t     op;
        logic        shl;
        logic        fin;
        logic [3:0]  entry;
    } mac_step_t;

    // product schedule for the nine entries of rz * ry * rx
    function automatic mac_step_t mac_step(input logic [4:0] idx);
        mac_step_t s;
        unique case (idx)
            5'd0:    s = '{SRC_CY, SRC_CZ,  OP_SET,  1'b1, 1'b1, 4'd0};
            5'd1:    s = '{SRC_SX, SRC_SY,  OP_T,    1'b0, 1'b0, 4'd0};
            5'd2:    s = '{SRC_T,  SRC_CZ,  OP_SET,  1'b0, 1'b0, 4'd0};
            5'd3:    s = '{SRC_CX, SRC_SZ,  OP_SUB,  1'b1, 1'b1, 4'd1};
            5'd4:    s = '{SRC_CX, SRC_SY,  OP_T,    1'b0, 1'b0, 4'd0};
            5'd5:    s = '{SRC_T,  SRC_CZ,  OP_SET,  1'b0, 1'b0, 4'd0};
            5'd6:    s = '{SRC_SX, SRC_SZ,  OP_ADD,  1'b1, 1'b1, 4'd2};
            5'd7:    s = '{SRC_CY, SRC_SZ,  OP_SET,  1'b1, 1'b1, 4'd3};
            5'd8:    s = '{SRC_SX, SRC_SY,  OP_T,    1'b0, 1'b0, 4'd0};
            5'd9:    s = '{SRC_CX, SRC_CZ,  OP_SET,  1'b1, 1'b0, 4'd0};
            5'd10:   s = '{SRC_T,  SRC_SZ,  OP_ADD,  1'b0, 1'b1, 4'd4};
            5'd11:   s = '{SRC_CX, SRC_SY,  OP_T,    1'b0, 1'b0, 4'd0};
            5'd12:   s = '{SRC_T,  SRC_SZ,  OP_SET,  1'b0, 1'b0, 4'd0};
            5'd13:   s = '{SRC_SX, SRC_CZ,  OP_SUB,  1'b1, 1'b1, 4'd5};
            5'd14:   s = '{SRC_SY, SRC_ONE, OP_SETN, 1'b1, 1'b1, 4'd6};
            5'd15:   s = '{SRC_SX, SRC_CY,  OP_SET,  1'b1, 1'b1, 4'd7};
            5'd16:   s = '{SRC_CX, SRC_CY,  OP_SET,  1'b1, 1'b1, 4'd8};
            default: s = '{SRC_SX, SRC_SX,  OP_T,    1'b0, 1'b0, 4'd0};
        endcase
        return s;
    endfunction

    // arctangent of 2^-k, truncated q30
    function automatic logic [29:0] atan_q30(input logic [4:0] k);
        logic [29:0] v;
        unique case (k)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            5'd31: v = 30'd0;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // entries below the tolerance count as zero
    function automatic logic signed [VALUE_WIDTH-1:0] snap(
        input logic signed [VALUE_WIDTH-1:0] v,
        input logic [9:0] tol
    );
        logic [VALUE_WIDTH-1:0] mag;
        mag = v[VALUE_WIDTH-1] ? VALUE_WIDTH'(-v) : VALUE_WIDTH'(v);
        return (mag < VALUE_WIDTH'(tol)) ? '0 : v;
    endfunction

endpackage

FILE: src/euler_rotation_matrix_engine_top.sv
// Keeps a 3x3 z-y-x rotation matrix (entries Q1.16, angles Q3.14). tuser kind 0 takes
// omega/phi/kappa, builds the matrix with one shared CORDIC stage and one shared 36x18
// multiplier, stores it and returns three row transfers (tlast on row 2); kind 1 loads
// the row given by row_index with no result; kind 2 decomposes the stored matrix through
// three CORDIC atan2 passes and a two-bit-per-cycle square root, then rebuilds and checks
// it, returning one transfer with the angles and a status. The block takes one item at a
// time; the CORDIC stage does one micro-rotation per cycle, CORDIC_STEPS of them per pass.
// Kind 0 runs three sine/cosine passes and the multiplier schedule; kind 2 runs the atan2
// passes (skipping one whose angle is undefined), the square sums and the square root,
// then the kind 0 work again; a stalled result transfer adds its wait. Kind 1 and unused
// kinds leave the block in idle. tolerance resets to 4.
module euler_rotation_matrix_engine_top
    import erme_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [9:0]   cfg_wr_data,     // tolerance
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,    // value_x, value_y, value_z, pad
    input  logic [3:0]   s_axis_tuser,    // kind, row_index
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,    // entry_a, entry_b, entry_c, omega, phi, kappa, pad
    output logic [3:0]   m_axis_tuser,    // row_number, status
    output logic         m_axis_tlast
);

    typedef enum logic [3:0] {
        S_IDLE, S_SC_INIT, S_SC_WRAP, S_CORD, S_SC_END, S_MAC, S_MAC_FLUSH, S_EMIT,
        S_AT_SEL, S_AT_LOAD, S_SQ_A, S_SQ_B, S_SQRT, S_AT_END, S_ANG_WRAP, S_RESULT
    } state_t;

    typedef logic signed [VALUE_WIDTH-1:0] val_t;

    state_t                 state_reg;
    logic [1:0]             pass_reg;
    val_t                   ang_reg [3];
    val_t                   store_reg [9];
    logic                   mvalid_reg;
    logic [9:0]             tol_reg;
    val_t                   sx_reg, cx_reg, sy_reg, cy_reg, sz_reg, cz_reg;
    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic [STEP_W-1:0]      cnt_reg;
    logic                   rot_reg;
    logic                   neg_reg;
    logic [SQ_W-1:0]        n_reg, res_reg, bit_reg;
    logic [4:0]             step_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [T_W-1:0]  t_reg;
    logic                   pend_reg;
    logic [3:0]             pend_idx_reg;
    logic                   check_reg;
    logic                   mism_reg;
    logic                   out_valid_reg;
    logic [1:0]             out_row_reg;
    val_t                   out_a_reg, out_b_reg, out_c_reg;
    val_t                   out_om_reg, out_ph_reg, out_ka_reg;
    status_t                out_status_reg;
    logic                   out_last_reg;

    kind_t                  in_kind;
    logic [1:0]             in_row;
    val_t                   in_x, in_y, in_z;
    val_t                   e0, e3, e6, e7, e8;
    val_t                   ang_sel;
    logic                   sigma;
    logic signed [XY_W-1:0] sh_x, sh_y, x_step, y_step;
    logic signed [Z_W-1:0]  atan_w, z_step;
    logic signed [XY_W-1:0] x_rnd, y_rnd;
    val_t                   c_val, s_val;
    logic signed [Z_W-1:0]  z_rnd;
    logic signed [19:0]     at_y, at_x;
    logic signed [XY_W-1:0] at_xs, at_ys;
    mac_step_t              st;
    logic signed [T_W-1:0]  mul_a;
    val_t                   mul_b;
    logic signed [T_W+VALUE_WIDTH-1:0] mul_p;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] wr_rnd;
    val_t                   wr_val;
    logic signed [VALUE_WIDTH:0] wr_diff;
    logic [VALUE_WIDTH:0]   wr_mag;
    logic [SQ_W:0]          sq_sum;
    logic signed [18:0]     a19;
    logic [3:0]             row_base;
    logic                   in_fire;
    logic                   out_load;

    assign in_kind  = kind_t'(s_axis_tuser[1:0]);
    assign in_row   = s_axis_tuser[3:2];
    assign in_x     = s_axis_tdata[17:0];
    assign in_y     = s_axis_tdata[35:18];
    assign in_z     = s_axis_tdata[53:36];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_load = (state_reg == S_EMIT || state_reg == S_RESULT)
                      && (!out_valid_reg || m_axis_tready);

    assign e0 = snap(store_reg[0], tol_reg);
    assign e3 = snap(store_reg[3], tol_reg);
    assign e6 = snap(store_reg[6], tol_reg);
    assign e7 = snap(store_reg[7], tol_reg);
    assign e8 = snap(store_reg[8], tol_reg);

    always_comb
    begin
        unique case (pass_reg)
            2'd0:    ang_sel = ang_reg[0];
            2'd1:    ang_sel = ang_reg[1];
            2'd2:    ang_sel = ang_reg[2];
            default: ang_sel = '0;
        endcase
    end

    // cordic micro-rotation
    assign sigma  = rot_reg ? (z_reg >= 0) : (y_reg <= 0);
    assign sh_x   = x_reg >>> cnt_reg;
    assign sh_y   = y_reg >>> cnt_reg;
    assign atan_w = signed'(Z_W'(atan_q30(5'(cnt_reg))));
    assign x_step = sigma ? (x_reg - sh_y) : (x_reg + sh_y);
    assign y_step = sigma ? (y_reg + sh_x) : (y_reg - sh_x);
    assign z_step = sigma ? (z_reg - atan_w) : (z_reg + atan_w);

    assign x_rnd = (x_reg + XY_W'(64'sd8192)) >>> 14;
    assign y_rnd = (y_reg + XY_W'(64'sd8192)) >>> 14;
    assign c_val = neg_reg ? -x_rnd[VALUE_WIDTH-1:0] : x_rnd[VALUE_WIDTH-1:0];
    assign s_val = neg_reg ? -y_rnd[VALUE_WIDTH-1:0] : y_rnd[VALUE_WIDTH-1:0];
    assign z_rnd = (z_reg + Z_W'(64'sd32768)) >>> 16;

    always_comb
    begin
        unique case (pass_reg)
            2'd0:
            begin
                at_y = 20'(e7);
                at_x = 20'(e8);
            end
            2'd1:
            begin
                at_y = -20'(e6);
                at_x = signed'({1'b0, res_reg[18:0]});
            end
            default:
            begin
                at_y = 20'(e3);
                at_x = 20'(e0);
            end
        endcase
    end
    assign at_xs = XY_W'(at_x) <<< 14;
    assign at_ys = XY_W'(at_y) <<< 14;

    // shared multiplier
    assign st = mac_step(step_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_SQ_A)
        begin
            mul_a = T_W'(e7);
            mul_b = e7;
        end
        else if (state_reg == S_SQ_B)
        begin
            mul_a = T_W'(e8);
            mul_b = e8;
        end
        else
        begin
            unique case (st.src_a)
                SRC_SX:  mul_a = T_W'(sx_reg);
                SRC_CX:  mul_a = T_W'(cx_reg);
                SRC_SY:  mul_a = T_W'(sy_reg);
                SRC_CY:  mul_a = T_W'(cy_reg);
                SRC_SZ:  mul_a = T_W'(sz_reg);
                SRC_CZ:  mul_a = T_W'(cz_reg);
                SRC_T:   mul_a = t_reg;
                default: mul_a = T_W'(UNIT16);
            endcase
            unique case (st.src_b)
                SRC_SX:  mul_b = sx_reg;
                SRC_CX:  mul_b = cx_reg;
                SRC_SY:  mul_b = sy_reg;
                SRC_CY:  mul_b = cy_reg;
                SRC_SZ:  mul_b = sz_reg;
                SRC_CZ:  mul_b = cz_reg;
                SRC_ONE: mul_b = UNIT16;
                default: mul_b = '0;
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;
    assign term  = st.shl ? (ACC_W'(mul_p) <<< 16) : ACC_W'(mul_p);

    // entry rounding and saturation
    assign wr_rnd = (acc_reg + ACC_RND) >>> 32;

    always_comb
    begin
        priority if (wr_rnd > ACC_W'(VAL_MAX))
            wr_val = VAL_MAX;
        else if (wr_rnd < ACC_W'(VAL_MIN))
            wr_val = VAL_MIN;
        else
            wr_val = wr_rnd[VALUE_WIDTH-1:0];
    end

    assign wr_diff = (VALUE_WIDTH+1)'(wr_val) - (VALUE_WIDTH+1)'(store_reg[pend_idx_reg]);
    assign wr_mag  = wr_diff[VALUE_WIDTH] ? (VALUE_WIDTH+1)'(-wr_diff)
                                          : (VALUE_WIDTH+1)'(wr_diff);

    assign sq_sum   = {1'b0, res_reg} + {1'b0, bit_reg};
    assign a19      = 19'(ang_sel);
    assign row_base = 4'({pass_reg, 1'b0}) + 4'(pass_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pass_reg       <= '0;
            for (int i = 0; i < 3; i++)
                ang_reg[i] <= '0;
            for (int i = 0; i < 9; i++)
                store_reg[i] <= '0;
            mvalid_reg     <= 1'b0;
            tol_reg        <= 10'd4;
            sx_reg         <= '0;
            cx_reg         <= '0;
            sy_reg         <= '0;
            cy_reg         <= '0;
            sz_reg         <= '0;
            cz_reg         <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            z_reg          <= '0;
            cnt_reg        <= '0;
            rot_reg        <= 1'b0;
            neg_reg        <= 1'b0;
            n_reg          <= '0;
            res_reg        <= '0;
            bit_reg        <= '0;
            step_reg       <= '0;
            acc_reg        <= '0;
            t_reg          <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            check_reg      <= 1'b0;
            mism_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_row_reg    <= '0;
            out_a_reg      <= '0;
            out_b_reg      <= '0;
            out_c_reg      <= '0;
            out_om_reg     <= '0;
            out_ph_reg     <= '0;
            out_ka_reg     <= '0;
            out_status_reg <= ST_OK;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                tol_reg <= cfg_wr_data;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;

            pend_reg <= (state_reg == S_MAC) && st.fin;

            // entry finished by the previous schedule step
            if (pend_reg)
            begin
                if (check_reg)
                begin
                    if (wr_mag > (VALUE_WIDTH+1)'(tol_reg))
                        mism_reg <= 1'b1;
                end
                else
                    store_reg[pend_idx_reg] <= wr_val;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (in_kind)
                            KIND_BUILD:
                            begin
                                ang_reg[0] <= in_x;
                                ang_reg[1] <= in_y;
                                ang_reg[2] <= in_z;
                                pass_reg   <= '0;
                                check_reg  <= 1'b0;
                                mvalid_reg <= 1'b1;
                                state_reg  <= S_SC_INIT;
                            end
                            KIND_LOAD:
                            begin
                                if (in_row != 2'd3)
                                begin
                                    store_reg[4'({in_row, 1'b0}) + 4'(in_row)]        <= in_x;
                                    store_reg[4'({in_row, 1'b0}) + 4'(in_row) + 4'd1] <= in_y;
                                    store_reg[4'({in_row, 1'b0}) + 4'(in_row) + 4'd2] <= in_z;
                                    mvalid_reg <= 1'b1;
                                end
                            end
                            KIND_DECOMP:
                            begin
                                pass_reg  <= '0;
                                mism_reg  <= 1'b0;
                                if (mvalid_reg)
                                    state_reg <= S_AT_SEL;
                                else
                                begin
                                    ang_reg[0] <= '0;
                                    ang_reg[1] <= '0;
                                    ang_reg[2] <= '0;
                                    state_reg  <= S_RESULT;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                S_SC_INIT:
                begin
                    z_reg     <= Z_W'(ang_sel) <<< 16;
                    state_reg <= S_SC_WRAP;
                end

                S_SC_WRAP:
                begin
                    priority if (z_reg > PI30)
                        z_reg <= z_reg - TWO_PI30;
                    else if (z_reg < -PI30)
                        z_reg <= z_reg + TWO_PI30;
                    else
                    begin
                        priority if (z_reg > HALF_PI30)
                        begin
                            z_reg   <= z_reg - PI30;
                            neg_reg <= 1'b1;
                        end
                        else if (z_reg < -HALF_PI30)
                        begin
                            z_reg   <= z_reg + PI30;
                            neg_reg <= 1'b1;
                        end
                        else
                            neg_reg <= 1'b0;
                        x_reg     <= GAIN30;
                        y_reg     <= '0;
                        cnt_reg   <= '0;
                        rot_reg   <= 1'b1;
                        state_reg <= S_CORD;
                    end
                end

                S_CORD:
                begin
                    x_reg   <= x_step;
                    y_reg   <= y_step;
                    z_reg   <= z_step;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
                        state_reg <= rot_reg ? S_SC_END : S_AT_END;
                end

                S_SC_END:
                begin
                    unique case (pass_reg)
                        2'd0:
                        begin
                            sx_reg <= s_val;
                            cx_reg <= c_val;
                        end
                        2'd1:
                        begin
                            sy_reg <= s_val;
                            cy_reg <= c_val;
                        end
                        default:
                        begin
                            sz_reg <= s_val;
                            cz_reg <= c_val;
                        end
                    endcase
                    if (pass_reg == 2'd2)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_MAC;
                    end
                    else
                    begin
                        pass_reg  <= pass_reg + 1'b1;
                        state_reg <= S_SC_INIT;
                    end
                end

                S_MAC:
                begin
                    unique case (st.op)
                        OP_T:    t_reg   <= mul_p[T_W-1:0];
                        OP_SET:  acc_reg <= term;
                        OP_SETN: acc_reg <= -term;
                        OP_ADD:  acc_reg <= acc_reg + term;
                        OP_SUB:  acc_reg <= acc_reg - term;
                        default: t_reg   <= mul_p[T_W-1:0];
                    endcase
                    if (st.fin)
                        pend_idx_reg <= st.entry;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'(MAC_STEPS - 1))
                        state_reg <= S_MAC_FLUSH;
                end

                S_MAC_FLUSH:
                begin
                    pass_reg  <= '0;
                    state_reg <= check_reg ? S_RESULT : S_EMIT;
                end

                S_EMIT:
                begin
                    if (out_load)
                    begin
                        out_row_reg    <= pass_reg;
                        out_a_reg      <= store_reg[row_base];
                        out_b_reg      <= store_reg[row_base + 4'd1];
                        out_c_reg      <= store_reg[row_base + 4'd2];
                        out_om_reg     <= '0;
                        out_ph_reg     <= '0;
                        out_ka_reg     <= '0;
                        out_status_reg <= ST_OK;
                        out_last_reg   <= (pass_reg == 2'd2);
                        if (pass_reg == 2'd2)
                            state_reg <= S_IDLE;
                        else
                            pass_reg <= pass_reg + 1'b1;
                    end
                end

                S_AT_SEL:
                begin
                    unique case (pass_reg)
                        2'd0:
                        begin
                            if (e7 != '0 || e8 != '0)
                                state_reg <= S_AT_LOAD;
                            else
                            begin
                                ang_reg[0] <= '0;
                                pass_reg   <= 2'd1;
                            end
                        end
                        2'd1:
                        begin
                            if (e6 != '0 || e7 != '0 || e8 != '0)
                                state_reg <= S_SQ_A;
                            else
                            begin
                                ang_reg[1] <= '0;
                                pass_reg   <= 2'd2;
                            end
                        end
                        2'd2:
                        begin
                            if (e3 != '0 || e0 != '0)
                                state_reg <= S_AT_LOAD;
                            else
                            begin
                                ang_reg[2] <= '0;
                                pass_reg   <= '0;
                                state_reg  <= S_ANG_WRAP;
                            end
                        end
                        default:
                        begin
                            pass_reg  <= '0;
                            state_reg <= S_ANG_WRAP;
                        end
                    endcase
                end

                S_AT_LOAD:
                begin
                    if (at_xs < 0)
                    begin
                        z_reg <= (at_ys >= 0) ? PI30 : -PI30;
                        x_reg <= -at_xs;
                        y_reg <= -at_ys;
                    end
                    else
                    begin
                        z_reg <= '0;
                        x_reg <= at_xs;
                        y_reg <= at_ys;
                    end
                    cnt_reg   <= '0;
                    rot_reg   <= 1'b0;
                    state_reg <= S_CORD;
                end

                S_SQ_A:
                begin
                    acc_reg   <= ACC_W'(mul_p);
                    state_reg <= S_SQ_B;
                end

                S_SQ_B:
                begin
                    n_reg     <= SQ_W'(acc_reg + ACC_W'(mul_p));
                    res_reg   <= '0;
                    bit_reg   <= SQ_W'(1) << (SQ_W - 2);
                    state_reg <= S_SQRT;
                end

                S_SQRT:
                begin
                    if ({1'b0, n_reg} >= sq_sum)
                    begin
                        n_reg   <= n_reg - sq_sum[SQ_W-1:0];
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                        res_reg <= res_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                        state_reg <= S_AT_LOAD;
                end

                S_AT_END:
                begin
                    unique case (pass_reg)
                        2'd0:    ang_reg[0] <= z_rnd[VALUE_WIDTH-1:0];
                        2'd1:    ang_reg[1] <= z_rnd[VALUE_WIDTH-1:0];
                        default: ang_reg[2] <= z_rnd[VALUE_WIDTH-1:0];
                    endcase
                    if (pass_reg == 2'd2)
                    begin
                        pass_reg  <= '0;
                        state_reg <= S_ANG_WRAP;
                    end
                    else
                    begin
                        pass_reg  <= pass_reg + 1'b1;
                        state_reg <= S_AT_SEL;
                    end
                end

                S_ANG_WRAP:
                begin
                    if (pass_reg == 2'd2)
                    begin
                        priority if (a19 < 0)
                            ang_reg[2] <= VALUE_WIDTH'(a19 + TWO_PI14);
                        else if (a19 >= TWO_PI14)
                            ang_reg[2] <= VALUE_WIDTH'(a19 - TWO_PI14);
                        else
                        begin
                            pass_reg  <= '0;
                            check_reg <= 1'b1;
                            state_reg <= S_SC_INIT;
                        end
                    end
                    else
                    begin
                        priority if (a19 < -PI14)
                        begin
                            if (pass_reg == 2'd0)
                                ang_reg[0] <= VALUE_WIDTH'(a19 + TWO_PI14);
                            else
                                ang_reg[1] <= VALUE_WIDTH'(a19 + TWO_PI14);
                        end
                        else if (a19 > PI14)
                        begin
                            if (pass_reg == 2'd0)
                                ang_reg[0] <= VALUE_WIDTH'(a19 - TWO_PI14);
                            else
                                ang_reg[1] <= VALUE_WIDTH'(a19 - TWO_PI14);
                        end
                        else
                            pass_reg <= pass_reg + 1'b1;
                    end
                end

                S_RESULT:
                begin
                    if (out_load)
                    begin
                        out_row_reg   <= '0;
                        out_a_reg     <= '0;
                        out_b_reg     <= '0;
                        out_c_reg     <= '0;
                        out_om_reg    <= ang_reg[0];
                        out_ph_reg    <= ang_reg[1];
                        out_ka_reg    <= ang_reg[2];
                        out_last_reg  <= 1'b1;
                        if (!mvalid_reg)
                            out_status_reg <= ST_NO_MATRIX;
                        else if (mism_reg)
                            out_status_reg <= ST_MISMATCH;
                        else
                            out_status_reg <= ST_OK;
                        state_reg <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_ka_reg, out_ph_reg, out_om_reg,
                            out_c_reg, out_b_reg, out_a_reg};
    assign m_axis_tuser  = {out_status_reg, out_row_reg};
    assign m_axis_tlast  = out_last_reg;

    // no matrix means the angles are zero
    a_no_matrix_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == ST_NO_MATRIX
        |-> out_om_reg == '0 && out_ph_reg == '0 && out_ka_reg == '0)
        else $error("angles not cleared with no matrix");

    // rows 1 and 2 only come from a build
    a_rows_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_row_reg != 2'd0 |-> out_status_reg == ST_OK)
        else $error("row transfer with bad status");

    // once a matrix is there it stays
    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mvalid_reg |=> mvalid_reg)
        else $error("matrix valid dropped");

    // no entry write left over when the block is ready
    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !pend_reg)
        else $error("entry write pending at idle");

endmodule
